// ===== rtl/argsrt_pkg.sv =====
package argsrt_pkg;

   // Capacity of the sorting chain and fixed field widths
   localparam int MAX_ITEMS_DEF = 64;
   localparam int KEY_W         = 64;
   localparam int POS_W         = 6;

   // Request payload: one key of the set
   typedef struct packed {
      logic [KEY_W-1:0] value;
      logic             last_item;
   } req_type;

   // Response payload: one arrival position in ascending key order
   typedef struct packed {
      logic [POS_W-1:0] position;
      logic             last_position;
      logic             dropped;
   } rsp_type;

   // Contents of one chain cell
   typedef struct packed {
      logic             valid;
      logic [KEY_W-1:0] key;
      logic [POS_W-1:0] pos;
   } cell_data_type;

   // Chain control broadcast to every cell
   typedef struct packed {
      logic insert;
      logic shift;
   } cell_ctrl_type;

   typedef enum logic {
      ST_LOAD,
      ST_DRAIN
   } state_type;

endpackage

// ===== rtl/argsort_ascending.sv =====
// Channel   | Ports                          | Moves
// ----------+--------------------------------+---------------------------------
// request   | req_valid req_ready req_data   | one key, last_item closes the set
// response  | rsp_valid rsp_ready rsp_data   | one arrival position, ascending
//
// Each request is taken whenever the block is loading; its key is inserted into a sorted chain of
// MAX_ITEMS cells, one compare per cell. A set of stored keys drains one response per
// cycle while rsp_ready is high, from the head cell, while no request is taken.
// The next set may start the cycle after the final response is taken.
// Reset empties the chain and clears count and drop flag.
// A stalled response holds the chain; requests beyond capacity are discarded.
module argsort_ascending #(
   parameter int MAX_ITEMS = argsrt_pkg::MAX_ITEMS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  argsrt_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output argsrt_pkg::rsp_type rsp_data
);

   localparam int CNT_W = $clog2(MAX_ITEMS + 1);

   argsrt_pkg::state_type     state_ff;
   argsrt_pkg::state_type     state_in;
   logic [CNT_W-1:0]          count_ff;
   logic [CNT_W-1:0]          count_in;
   logic                      overflow_ff;
   logic                      overflow_in;

   logic                      req_fire;
   logic                      rsp_fire;
   logic                      has_room;
   argsrt_pkg::cell_ctrl_type ctrl;
   argsrt_pkg::cell_data_type new_item;

   argsrt_pkg::cell_data_type chain_data [MAX_ITEMS];
   logic [MAX_ITEMS-1:0]      chain_ins;
   logic [MAX_ITEMS-1:0]      cell_vld;
   logic [MAX_ITEMS-1:0]      vld_inc;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;
   assign has_room = count_ff < CNT_W'(MAX_ITEMS);

   // Build the item to insert, tagged by its arrival position
   always_comb begin
      new_item.valid = 1'b1;
      new_item.key   = req_data.value;
      new_item.pos   = argsrt_pkg::POS_W'(count_ff);
   end

   assign ctrl.insert = req_fire && has_room;
   assign ctrl.shift  = rsp_fire;

   // Sorting chain, smallest key at cell 0
   for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
      argsrt_pkg::cell_data_type prev_d;
      argsrt_pkg::cell_data_type next_d;
      logic                      prev_i;

      if (i == 0) begin : g_head
         assign prev_d = '0;
         assign prev_i = 1'b0;
      end else begin : g_body
         assign prev_d = chain_data[i-1];
         assign prev_i = chain_ins[i-1];
      end

      if (i == MAX_ITEMS - 1) begin : g_tail
         assign next_d = '0;
      end else begin : g_link
         assign next_d = chain_data[i+1];
      end

      argsrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .new_item  (new_item),
         .prev_data (prev_d),
         .prev_ins  (prev_i),
         .next_data (next_d),
         .data      (chain_data[i]),
         .ins       (chain_ins[i])
      );

      assign cell_vld[i] = chain_data[i].valid;
   end

   assign vld_inc = cell_vld + MAX_ITEMS'(1);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         argsrt_pkg::ST_LOAD: begin
            if (req_fire && req_data.last_item) begin
               state_in = argsrt_pkg::ST_DRAIN;
            end
         end
         argsrt_pkg::ST_DRAIN: begin
            if (rsp_fire && (count_ff == CNT_W'(1))) begin
               state_in = argsrt_pkg::ST_LOAD;
            end
         end
         default: state_in = argsrt_pkg::ST_LOAD;
      endcase
   end

   // Handshake outputs
   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         argsrt_pkg::ST_LOAD:  req_ready = 1'b1;
         argsrt_pkg::ST_DRAIN: rsp_valid = 1'b1;
         default: begin
            req_ready = 1'b0;
            rsp_valid = 1'b0;
         end
      endcase
   end

   // Count stored keys while loading, count down remaining responses while draining
   always_comb begin
      count_in    = count_ff;
      overflow_in = overflow_ff;
      if (req_fire) begin
         if (has_room) begin
            count_in = count_ff + CNT_W'(1);
         end else begin
            overflow_in = 1'b1;
         end
      end
      if (rsp_fire) begin
         count_in = count_ff - CNT_W'(1);
         if (count_ff == CNT_W'(1)) begin
            overflow_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= argsrt_pkg::ST_LOAD;
         count_ff    <= '0;
         overflow_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         overflow_ff <= overflow_in;
      end
   end

   // Response comes straight from the head cell
   always_comb begin
      rsp_data.position      = chain_data[0].pos;
      rsp_data.last_position = (count_ff == CNT_W'(1));
      rsp_data.dropped       = overflow_ff;
   end

   a_head_valid : assert property (@(posedge clock) disable iff (reset)
      (state_ff == argsrt_pkg::ST_DRAIN) |-> (chain_data[0].valid && (count_ff != '0)))
      else $error("draining with an empty chain head");

   a_run_end : assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_data.last_position) |=>
         ((state_ff == argsrt_pkg::ST_LOAD) && (count_ff == '0) && !overflow_ff
          && (cell_vld == '0)))
      else $error("set state not cleared after final response");

   a_vld_prefix : assert property (@(posedge clock) disable iff (reset)
      (cell_vld & vld_inc) == '0)
      else $error("occupied cells not contiguous from the head");

   a_vld_count : assert property (@(posedge clock) disable iff (reset)
      $countones(cell_vld) == int'(count_ff))
      else $error("occupied cells disagree with item count");

endmodule

// ===== rtl/argsrt_cell.sv =====
module argsrt_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  argsrt_pkg::cell_ctrl_type ctrl,
   input  argsrt_pkg::cell_data_type new_item,
   input  argsrt_pkg::cell_data_type prev_data,
   input  logic                      prev_ins,
   input  argsrt_pkg::cell_data_type next_data,
   output argsrt_pkg::cell_data_type data,
   output logic                      ins
);

   argsrt_pkg::cell_data_type data_ff;
   argsrt_pkg::cell_data_type data_in;

   // New key goes ahead of this cell when the cell is empty or holds a larger key;
   // equal keys stay ahead, which keeps arrival order among them
   assign ins = !data_ff.valid || (new_item.key < data_ff.key);

   // Select next contents: take the left neighbor, the new key, the right neighbor or hold
   always_comb begin
      data_in = data_ff;
      if (ctrl.insert) begin
         if (prev_ins) begin
            data_in = prev_data;
         end else if (ins) begin
            data_in       = new_item;
            data_in.valid = 1'b1;
         end
      end else if (ctrl.shift) begin
         data_in = next_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff.valid <= 1'b0;
      end else begin
         data_ff.valid <= data_in.valid;
      end
      data_ff.key <= data_in.key;
      data_ff.pos <= data_in.pos;
   end

   assign data = data_ff;

endmodule

// ===== tb/tb_argsort_ascending.sv =====
module tb_argsort_ascending;

   localparam int CAPACITY    = argsrt_pkg::MAX_ITEMS_DEF;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_WAIT  = 2 * CAPACITY + 20;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   argsrt_pkg::req_type req_data = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   argsrt_pkg::rsp_type rsp_data;

   // Shadow of the set being loaded and the positions still to come out
   logic [argsrt_pkg::KEY_W-1:0] set_keys [CAPACITY];
   int                           set_count = 0;
   logic                         set_overflow = 1'b0;
   argsrt_pkg::rsp_type          pending_positions [$];

   int req_idle_pct  = 0;
   int rsp_stall_pct = 0;
   int error_count   = 0;
   int cycle_count   = 0;

   argsort_ascending #(
      .MAX_ITEMS(CAPACITY)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Store one accepted key; on the closing request rank the set stably
   function automatic void load_key(input argsrt_pkg::req_type r);
      int order [CAPACITY];
      int rank;
      argsrt_pkg::rsp_type p;
      if (set_count < CAPACITY) begin
         set_keys[set_count] = r.value;
         set_count++;
      end else begin
         set_overflow = 1'b1;
      end
      if (r.last_item) begin
         for (int i = 0; i < set_count; i++) begin
            rank = 0;
            for (int j = 0; j < set_count; j++) begin
               if (set_keys[j] < set_keys[i] || (set_keys[j] == set_keys[i] && j < i))
                  rank++;
            end
            order[rank] = i;
         end
         for (int k = 0; k < set_count; k++) begin
            p.position      = order[k][argsrt_pkg::POS_W-1:0];
            p.last_position = (k == set_count - 1);
            p.dropped       = set_overflow;
            pending_positions = {pending_positions, p};
         end
         set_count    = 0;
         set_overflow = 1'b0;
      end
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch at cycle %0d: %s got %0d, expected %0d", cycle_count, what,
               got, want);
      error_count++;
   endtask

   // Compare one response against the oldest pending position
   task automatic check_response(input argsrt_pkg::rsp_type got);
      argsrt_pkg::rsp_type want;
      if (pending_positions.size() == 0) begin
         report_mismatch("unexpected response, position", int'(got.position), 0);
      end else begin
         want = pending_positions.pop_front();
         if (got.position !== want.position)
            report_mismatch("position", int'(got.position), int'(want.position));
         if (got.last_position !== want.last_position)
            report_mismatch("last_position", int'(got.last_position),
                            int'(want.last_position));
         if (got.dropped !== want.dropped)
            report_mismatch("dropped", int'(got.dropped), int'(want.dropped));
      end
   endtask

   // Watch both channels at each edge
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         load_key(req_data);
      if (!reset && rsp_valid && rsp_ready)
         check_response(rsp_data);
   end

   // Stall the response channel at random
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Bound the run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Present one request and hold it until taken; valid stays high for a
   // back-to-back follower and is lowered only when idling
   task automatic send_req(input logic [argsrt_pkg::KEY_W-1:0] value, input logic last);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_data.value     <= value;
      req_data.last_item <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Drop valid and hold off until every pending position has come out
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_positions.size() != 0) @(posedge clock);
   endtask

   function automatic logic [argsrt_pkg::KEY_W-1:0] next_key(input bit narrow);
      logic [argsrt_pkg::KEY_W-1:0] k;
      if (narrow) begin
         case ($urandom_range(4))
            0: k = '1;
            default: k = argsrt_pkg::KEY_W'($urandom_range(3));
         endcase
      end else begin
         case ($urandom_range(9))
            0: k = '0;
            1: k = '1;
            default: k = {$urandom, $urandom};
         endcase
      end
      return k;
   endfunction

   task automatic send_set(input int size, input bit narrow);
      for (int k = 0; k < size; k++)
         send_req(next_key(narrow), k == size - 1);
   endtask

   task automatic test_single_sets();
      send_req('0, 1'b1);
      send_req('1, 1'b1);
   endtask

   task automatic test_extreme_keys();
      send_req('1, 1'b0);
      send_req('0, 1'b0);
      send_req(64'h1, 1'b0);
      send_req(64'hFFFF_FFFF_FFFF_FFFE, 1'b0);
      send_req(64'h8000_0000_0000_0000, 1'b0);
      send_req(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
      send_req(64'hAAAA_AAAA_5555_5555, 1'b1);
   endtask

   // Equal keys must come out in arrival order
   task automatic test_equal_keys();
      send_req(64'd5, 1'b0);
      send_req(64'd5, 1'b0);
      send_req(64'd3, 1'b0);
      send_req(64'd5, 1'b0);
      send_req(64'd5, 1'b1);
      send_req('1, 1'b0);
      send_req('1, 1'b0);
      send_req('1, 1'b0);
      send_req('1, 1'b1);
   endtask

   task automatic test_drain_pause();
      send_set(3, 1'b0);
      wait_drained();
      send_set(2, 1'b1);
   endtask

   // Exactly full, full with the closing request discarded, and well past full
   task automatic test_capacity();
      send_set(CAPACITY, 1'b0);
      send_set(CAPACITY + 1, 1'b1);
      send_set(CAPACITY + 5, 1'b0);
   endtask

   task automatic run_random_sets(input int item_budget);
      int sent;
      int size;
      sent = 0;
      while (sent < item_budget) begin
         if ($urandom_range(99) < 85)
            size = $urandom_range(12, 1);
         else
            size = $urandom_range(CAPACITY - 1, 13);
         send_set(size, $urandom_range(2) == 0);
         sent += size;
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      req_idle_pct  = 15;
      rsp_stall_pct = 68;
      test_single_sets();
      test_extreme_keys();
      test_equal_keys();
      test_drain_pause();
      run_random_sets(70);

      req_idle_pct  = 68;
      rsp_stall_pct = 15;
      test_capacity();
      run_random_sets(70);

      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      run_random_sets(70);

      // Let the last set drain, then watch for stray responses
      wait_drained();
      repeat (DRAIN_WAIT) @(posedge clock);

      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/argsrt_pkg.sv
rtl/argsrt_cell.sv
rtl/argsort_ascending.sv
tb/tb_argsort_ascending.sv
